>>> src/wscfr_pkg.sv
// ----------------------------------------------------------------------------
// wscfr_pkg
// Shared types and codes for the working-set clock frame replacer.
// ----------------------------------------------------------------------------
package wscfr_pkg;

  localparam logic [2:0] ACT_ALLOC = 3'd0;
  localparam logic [2:0] ACT_FREE  = 3'd1;
  localparam logic [2:0] ACT_REF   = 3'd2;
  localparam logic [2:0] ACT_TICK  = 3'd3;
  localparam logic [2:0] ACT_MAINT = 3'd4;
  localparam logic [2:0] ACT_EVICT = 3'd5;

  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_COUNT  = 1'b1;

  localparam logic KIND_WB   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic scan_init;  // start a scan at frame 0
    logic hand_init;  // start a sweep at the hand
    logic step;       // process current frame and advance
    logic finish;     // apply end-of-action update, build completion
    logic emit_wb;    // build writeback result from current frame
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [2:0] action;
    logic       scan_free;  // current scan frame is free
    logic       scan_end;   // current scan frame is the last of the pool
    logic       empty;      // used_total is zero
    logic       wb_now;     // current sweep frame needs a writeback
    logic       victim_now; // current sweep frame is the victim
    logic       lap_end;    // advancing reaches the start frame
  } stat_t;

endpackage

>>> src/wscfr_ctrl.sv
// ----------------------------------------------------------------------------
// wscfr_ctrl
// Sequencer: one action at a time; scans/unstalled sweeps do a frame a cycle.
// ----------------------------------------------------------------------------
module wscfr_ctrl
  import wscfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_fire,
  input  logic  out_busy,
  input  stat_t st,
  output logic  in_ready,
  output logic  out_load,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state, state_next;

  assign in_ready = (state == S_IDLE);

  // decode next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (st.action == ACT_ALLOC) begin
          cmd.scan_init = 1'b1;
          state_next = S_SCAN;
        end else if (st.action == ACT_EVICT) begin
          cmd.hand_init = 1'b1;
          state_next = st.empty ? S_FIN : S_SWEEP;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SCAN: begin
        if (st.scan_free) begin
          state_next = S_FIN;
        end else if (st.scan_end) begin
          cmd.hand_init = 1'b1;
          state_next = st.empty ? S_FIN : S_SWEEP;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_SWEEP: begin
        if (!out_busy) begin
          if (st.victim_now) begin
            state_next = S_FIN;
          end else begin
            cmd.step = 1'b1;
            if (st.wb_now) begin
              cmd.emit_wb = 1'b1;
              out_load = 1'b1;
            end
            if (st.lap_end) state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // a completion or writeback never leaves while the output still holds one
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !out_busy) else $error("result overwritten");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_DEC) else $error("accept outside idle");
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == S_IDLE) else $error("finish did not return idle");

endmodule

>>> src/wscfr_dp.sv
// ----------------------------------------------------------------------------
// wscfr_dp
// Frame table, clock hand, time, configuration and result register.
// ----------------------------------------------------------------------------
module wscfr_dp
  import wscfr_pkg::*;
#(
  parameter int FRAMES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [2:0]  action,
  input  logic [19:0] page_number,
  input  logic [4:0]  frame_index,
  input  logic        is_write,
  input  cmd_t        cmd,
  input  logic        out_load,
  input  logic        out_take,
  output stat_t       st,
  output logic        out_busy,
  output logic        kind,
  output logic [4:0]  frame_out,
  output logic [19:0] page_out,
  output logic        evicted,
  output logic        status,
  output logic        last
);

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NW = $clog2(FRAMES + 1);

  logic [31:0] ws_window;
  logic [5:0]  frame_count;
  logic [2:0]  act;
  logic [19:0] page;
  logic [4:0]  fi;
  logic        wr;

  logic [FRAMES-1:0] used, fdirty, acc, pdirty;
  logic [19:0] fpage [FRAMES];
  logic [31:0] lastuse [FRAMES];
  logic [FW-1:0] hand, ptr, start;
  logic [NW-1:0] used_total;
  logic [31:0] now;
  logic        valid;
  logic        sweeping;

  // pool size clamped to 1..FRAMES
  logic [NW-1:0] n;
  always_comb begin
    if (frame_count == 6'd0) n = NW'(1);
    else if ({26'd0, frame_count} > 32'(FRAMES)) n = NW'(FRAMES);
    else n = NW'(frame_count);
  end

  logic [FW-1:0] ptr_inc;
  logic [31:0]   age;
  logic          fi_ok;
  assign ptr_inc = ({{(NW-FW){1'b0}}, ptr} + NW'(1) >= n) ? '0 : ptr + FW'(1);
  assign age     = now - lastuse[ptr];
  assign fi_ok   = ({27'd0, fi} < 32'(n)) && used[fi[FW-1:0]];

  // status toward the controller
  always_comb begin
    st.action     = act;
    st.scan_free  = !used[ptr];
    st.scan_end   = ({{(NW-FW){1'b0}}, ptr} + NW'(1) >= n);
    st.empty      = (used_total == '0);
    st.wb_now     = used[ptr] && !acc[ptr] && fdirty[ptr];
    st.victim_now = used[ptr] && !acc[ptr] && !fdirty[ptr] && (age > ws_window);
    st.lap_end    = (ptr_inc == start);
  end

  logic fin_alloc_ok;
  assign fin_alloc_ok = !st.empty || !used[ptr];

  // configuration, frame state and hand
  always_ff @(posedge clk) begin
    if (rst) begin
      ws_window  <= 32'd100;
      frame_count <= 6'd32;
      used <= '0; fdirty <= '0; acc <= '0; pdirty <= '0;
      hand <= '0; ptr <= '0; start <= '0;
      used_total <= '0; now <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WINDOW) ws_window <= cfg_data;
        else                         frame_count <= cfg_data[5:0];
      end
      if (cmd.load) begin
        act <= action; page <= page_number; fi <= frame_index; wr <= is_write;
      end
      if (cmd.scan_init) ptr <= '0;
      if (cmd.hand_init) begin
        if ({{(NW-FW){1'b0}}, hand} >= n) begin
          ptr <= '0; start <= '0;
        end else begin
          ptr <= hand; start <= hand;
        end
      end
      // sweep step: refresh, clean, skip
      if (cmd.step) ptr <= ptr_inc;
      if (cmd.step && (cmd.emit_wb || used[ptr])) begin
        if (acc[ptr] && sweeping) begin
          lastuse[ptr] <= now;
          acc[ptr] <= 1'b0;
        end else if (cmd.emit_wb) begin
          fdirty[ptr] <= 1'b0;
          pdirty[ptr] <= 1'b0;
        end
      end
      if (cmd.step && sweeping && st.lap_end) hand <= ptr_inc;
      // end-of-action updates
      if (cmd.finish) begin
        unique case (act)
          ACT_ALLOC: begin
            if (fin_alloc_ok) begin
              used[ptr] <= 1'b1; fpage[ptr] <= page; lastuse[ptr] <= now;
              fdirty[ptr] <= 1'b0; acc[ptr] <= 1'b0; pdirty[ptr] <= 1'b0;
              if (!st.scan_free) hand <= ptr_inc;
              else used_total <= used_total + NW'(1);
            end
          end
          ACT_FREE: begin
            if (fi_ok) begin
              used[fi[FW-1:0]] <= 1'b0; fdirty[fi[FW-1:0]] <= 1'b0;
              acc[fi[FW-1:0]] <= 1'b0; pdirty[fi[FW-1:0]] <= 1'b0;
              used_total <= used_total - NW'(1);
            end
          end
          ACT_REF: begin
            if (fi_ok) begin
              acc[fi[FW-1:0]] <= 1'b1;
              if (wr) pdirty[fi[FW-1:0]] <= 1'b1;
            end
          end
          ACT_TICK: now <= now + 32'd1;
          ACT_MAINT: begin
            for (int i = 0; i < FRAMES; i++) begin
              if (i < int'(n) && used[i]) begin
                if (acc[i]) begin
                  lastuse[i] <= now; acc[i] <= 1'b0;
                end
                if (pdirty[i]) fdirty[i] <= 1'b1;
              end
            end
          end
          ACT_EVICT: begin
            if (!st.empty) begin
              if (used[ptr]) begin
                used[ptr] <= 1'b0; fdirty[ptr] <= 1'b0;
                acc[ptr] <= 1'b0; pdirty[ptr] <= 1'b0;
                used_total <= used_total - NW'(1);
              end
              hand <= ptr_inc;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // true while the pointer walks from the hand
  always_ff @(posedge clk) begin
    if (rst) sweeping <= 1'b0;
    else if (cmd.hand_init) sweeping <= 1'b1;
    else if (cmd.finish || cmd.load) sweeping <= 1'b0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (out_load) valid <= 1'b1;
    else if (out_take) valid <= 1'b0;
  end
  assign out_busy = valid && !out_take;

  // build the next result beat
  logic        kind_next, evicted_next, status_next, last_next;
  logic [4:0]  frame_out_next;
  logic [19:0] page_out_next;
  always_comb begin
    kind_next = KIND_DONE; frame_out_next = '0; page_out_next = '0;
    evicted_next = 1'b0; status_next = 1'b0; last_next = 1'b1;
    if (cmd.emit_wb) begin
      kind_next = KIND_WB; frame_out_next = 5'(ptr);
      page_out_next = fpage[ptr]; last_next = 1'b0;
    end else begin
      unique case (act)
        ACT_ALLOC: begin
          if (!fin_alloc_ok) status_next = 1'b1;
          else begin
            frame_out_next = 5'(ptr);
            if (!st.scan_free) begin
              page_out_next = fpage[ptr]; evicted_next = 1'b1;
            end
          end
        end
        ACT_FREE, ACT_REF: frame_out_next = fi;
        ACT_EVICT: begin
          if (st.empty) status_next = 1'b1;
          else begin
            frame_out_next = 5'(ptr);
            if (used[ptr]) begin
              page_out_next = fpage[ptr]; evicted_next = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind <= kind_next; frame_out <= frame_out_next; page_out <= page_out_next;
      evicted <= evicted_next; status <= status_next; last <= last_next;
    end
  end

  a_total: assert property (@(posedge clk) disable iff (rst)
    used_total <= NW'(FRAMES)) else $error("used count overflow");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> {{(NW-FW){1'b0}}, ptr} < n || cfg_we || $past(cfg_we))
    else $error("sweep pointer outside pool");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_busy && !out_load |=> $stable(frame_out)) else $error("result changed");

endmodule

>>> src/ws_clock_frame_replacer.sv
// ----------------------------------------------------------------------------
// ws_clock_frame_replacer
// Frame pool managed with the working-set clock replacement policy.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one action beat (action,
// page_number, frame_index, is_write). Output channel: out_valid / out_stall
// carry result beats; each action yields zero or more writebacks, then one
// completion with last set.
// One action is handled at a time; in_stall stays high from the accepting
// edge until the completion is loaded. Tick, free, reference, maintenance and
// undefined actions pass through the decode and finish states to the
// completion. Allocate scans one frame a cycle for a free frame (up to the
// pool size), then, when none is free, sweeps from the clock hand one frame
// a cycle while the output is not stalled, up to one lap; evict runs only
// the sweep.
// Reset clears all frames to free, the hand and the time; ws_window returns
// to 100 and frame_count to 32. A stalled result holds the output register
// and pauses the sweep; input is not taken until the completion is loaded.
// Configuration writes go through cfg_we / cfg_index / cfg_data.
// ----------------------------------------------------------------------------
module ws_clock_frame_replacer
  import wscfr_pkg::*;
#(
  parameter int FRAMES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [19:0] page_number,
  input  logic [4:0]  frame_index,
  input  logic        is_write,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [4:0]  frame_out,
  output logic [19:0] page_out,
  output logic        evicted,
  output logic        status,
  output logic        last
);

  cmd_t  cmd;
  stat_t st;
  logic  in_ready, out_load, out_busy, in_fire, vld;

  assign in_stall  = !in_ready;
  assign in_fire   = in_valid && in_ready;

  // output valid mirrors the result register
  always_ff @(posedge clk) begin
    if (rst) vld <= 1'b0;
    else if (out_load) vld <= 1'b1;
    else if (!out_stall) vld <= 1'b0;
  end
  assign out_valid = vld;

  wscfr_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_busy, .st, .in_ready, .out_load, .cmd
  );

  wscfr_dp #(.FRAMES(FRAMES)) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .action, .page_number,
    .frame_index, .is_write, .cmd, .out_load, .out_take(vld && !out_stall),
    .st, .out_busy, .kind, .frame_out, .page_out, .evicted, .status, .last
  );

endmodule
